>>> src/cfir_pkg.sv
// Shared types, constants and state encodings for the MIMO complex FIR block.
`default_nettype none
package cfir_pkg;

	localparam int DEF_MAX_RX   = 4;
	localparam int DEF_MAX_TX   = 4;
	localparam int DEF_MAX_TAPS = 32;

	localparam int SAMP_W  = 16;
	localparam int GAIN_W  = 16;
	localparam int ADDR_W  = 9;
	localparam int CFG_IW  = 2;
	localparam int CFG_DW  = 16;
	localparam int PORT_TX = 4;

	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	typedef enum logic [1:0] {
		REG_NUM_RX   = 2'd0,
		REG_NUM_TX   = 2'd1,
		REG_NUM_TAPS = 2'd2,
		REG_GAIN     = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_MERGE
	} top_state_t;

	typedef enum logic [2:0] {
		MS_IDLE,
		MS_SUM,
		MS_MUL,
		MS_ADD,
		MS_OUT,
		MS_WAIT
	} merge_state_t;

	typedef struct packed {
		logic vld;
		logic use_tap;
	} pipe_ctl_t;

	function automatic int acc_w(input int taps);
		return 33 + $clog2(taps);
	endfunction

	function automatic int idx_w(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage
`default_nettype wire

>>> src/cfir_hist.sv
// Circular sample history of one transmit antenna with registered read.
`default_nettype none
module cfir_hist #(
	parameter int MAX_TAPS = cfir_pkg::DEF_MAX_TAPS,
	parameter int IW       = cfir_pkg::idx_w(MAX_TAPS),
	parameter int CW       = $clog2(MAX_TAPS + 1)
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                push,
	input  wire logic signed [cfir_pkg::SAMP_W-1:0]  push_re,
	input  wire logic signed [cfir_pkg::SAMP_W-1:0]  push_im,
	input  wire logic [CW-1:0]                       rd_d,
	output logic signed [cfir_pkg::SAMP_W-1:0]       samp_re,
	output logic signed [cfir_pkg::SAMP_W-1:0]       samp_im
);
	logic [2*cfir_pkg::SAMP_W-1:0] mem [MAX_TAPS];
	logic [IW-1:0] wp_q;
	logic [IW-1:0] wp_next;
	logic [CW:0]   wpx;
	logic [CW:0]   dx;
	logic [CW:0]   ra;
	logic [2*cfir_pkg::SAMP_W-1:0] rd_s1;

	always_comb begin
		wp_next = (32'(wp_q) == MAX_TAPS - 1) ? '0 : wp_q + IW'(1);
		wpx = (CW+1)'(wp_q);
		dx  = (CW+1)'(rd_d);
		if (wpx >= dx) begin
			ra = wpx - dx;
		end else begin
			ra = wpx + (CW+1)'(MAX_TAPS) - dx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
		end else if (push) begin
			wp_q <= wp_next;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_next] <= {push_re, push_im};
		end
		rd_s1 <= mem[ra[IW-1:0]];
	end

	assign samp_re = rd_s1[2*cfir_pkg::SAMP_W-1:cfir_pkg::SAMP_W];
	assign samp_im = rd_s1[cfir_pkg::SAMP_W-1:0];
endmodule
`default_nettype wire

>>> src/cfir_lane.sv
// One antenna pair lane: tap memory, complex multiplier and accumulator.
`default_nettype none
module cfir_lane #(
	parameter int MAX_TAPS = cfir_pkg::DEF_MAX_TAPS,
	parameter int IW       = cfir_pkg::idx_w(MAX_TAPS),
	parameter int ACC_W    = cfir_pkg::acc_w(MAX_TAPS)
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                wr_en,
	input  wire logic [IW-1:0]                       wr_addr,
	input  wire logic signed [cfir_pkg::SAMP_W-1:0]  wr_re,
	input  wire logic signed [cfir_pkg::SAMP_W-1:0]  wr_im,
	input  wire logic [IW-1:0]                       rd_addr,
	input  wire cfir_pkg::pipe_ctl_t                 ctl,
	input  wire logic                                act,
	input  wire logic                                clr,
	input  wire logic signed [cfir_pkg::SAMP_W-1:0]  samp_re,
	input  wire logic signed [cfir_pkg::SAMP_W-1:0]  samp_im,
	output logic signed [ACC_W-1:0]                  acc_re,
	output logic signed [ACC_W-1:0]                  acc_im
);
	logic [2*cfir_pkg::SAMP_W-1:0] mem [MAX_TAPS];
	logic [2*cfir_pkg::SAMP_W-1:0] tap_s1;
	cfir_pkg::pipe_ctl_t ctl_s1;
	cfir_pkg::pipe_ctl_t ctl_s2;
	logic signed [cfir_pkg::SAMP_W-1:0] c_re;
	logic signed [cfir_pkg::SAMP_W-1:0] c_im;
	logic signed [31:0] rr_s2, ii_s2, ir_s2, ri_s2;
	logic signed [ACC_W-1:0] acc_re_q, acc_im_q;

	assign c_re = tap_s1[2*cfir_pkg::SAMP_W-1:cfir_pkg::SAMP_W];
	assign c_im = tap_s1[cfir_pkg::SAMP_W-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_re, wr_im};
		end
		tap_s1 <= mem[rd_addr];
		rr_s2  <= samp_re * c_re;
		ii_s2  <= samp_im * c_im;
		ir_s2  <= samp_im * c_re;
		ri_s2  <= samp_re * c_im;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1   <= '0;
			ctl_s2   <= '0;
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			if (clr) begin
				acc_re_q <= '0;
				acc_im_q <= '0;
			end else if (ctl_s2.vld && ctl_s2.use_tap && act) begin
				acc_re_q <= acc_re_q + ACC_W'(rr_s2) - ACC_W'(ii_s2);
				acc_im_q <= acc_im_q + ACC_W'(ir_s2) + ACC_W'(ri_s2);
			end
		end
	end

	assign acc_re = acc_re_q;
	assign acc_im = acc_im_q;
endmodule
`default_nettype wire

>>> src/cfir_merge.sv
// Merge stage: sums lanes per receive antenna, applies gain, rounds and saturates.
`default_nettype none
module cfir_merge #(
	parameter int MAX_RX   = cfir_pkg::DEF_MAX_RX,
	parameter int MAX_TX   = cfir_pkg::DEF_MAX_TX,
	parameter int MAX_TAPS = cfir_pkg::DEF_MAX_TAPS,
	parameter int ACC_W    = cfir_pkg::acc_w(MAX_TAPS),
	parameter int RW       = cfir_pkg::idx_w(MAX_RX),
	parameter int NRW      = $clog2(MAX_RX + 1)
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic [NRW-1:0]                      nr,
	input  wire logic [cfir_pkg::GAIN_W-1:0]         gain,
	input  wire logic signed [ACC_W-1:0]             acc_re [MAX_RX*MAX_TX],
	input  wire logic signed [ACC_W-1:0]             acc_im [MAX_RX*MAX_TX],
	input  wire logic                                out_ready,
	output logic                                     out_valid,
	output logic [1:0]                               rx_index,
	output logic signed [cfir_pkg::SAMP_W-1:0]       out_re,
	output logic signed [cfir_pkg::SAMP_W-1:0]       out_im,
	output logic                                     saturated,
	output logic                                     last,
	output logic                                     busy
);
	localparam int SW = ACC_W + $clog2(MAX_TX) + 1;
	localparam int PW = SW + 9;
	localparam int TW = SW + 17;
	localparam int QW = TW - 28;

	cfir_pkg::merge_state_t state_q, state_d;
	logic [RW-1:0] r_q;
	logic          r_last;
	logic signed [SW-1:0] sum_re_d, sum_im_d, sum_re_q, sum_im_q;
	logic signed [PW-1:0] plo_re_q, phi_re_q, plo_im_q, phi_im_q;
	logic signed [TW-1:0] tot_re_q, tot_im_q;
	logic signed [QW-1:0] q_re, q_im;
	logic sat_re_hi, sat_re_lo, sat_im_hi, sat_im_lo;
	logic out_valid_q;

	assign r_last = (NRW'(r_q) + NRW'(1)) == nr;

	always_comb begin
		sum_re_d = '0;
		sum_im_d = '0;
		for (int t = 0; t < MAX_TX; t++) begin
			sum_re_d = sum_re_d + SW'(acc_re[int'(r_q) * MAX_TX + t]);
			sum_im_d = sum_im_d + SW'(acc_im[int'(r_q) * MAX_TX + t]);
		end
		q_re = QW'((tot_re_q + (TW'(1) <<< 27)) >>> 28);
		q_im = QW'((tot_im_q + (TW'(1) <<< 27)) >>> 28);
		sat_re_hi = q_re > QW'(32767);
		sat_re_lo = q_re < -QW'(32768);
		sat_im_hi = q_im > QW'(32767);
		sat_im_lo = q_im < -QW'(32768);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			cfir_pkg::MS_IDLE: if (start) state_d = cfir_pkg::MS_SUM;
			cfir_pkg::MS_SUM:  state_d = cfir_pkg::MS_MUL;
			cfir_pkg::MS_MUL:  state_d = cfir_pkg::MS_ADD;
			cfir_pkg::MS_ADD:  state_d = cfir_pkg::MS_OUT;
			cfir_pkg::MS_OUT:  state_d = cfir_pkg::MS_WAIT;
			cfir_pkg::MS_WAIT: begin
				if (out_ready) begin
					state_d = r_last ? cfir_pkg::MS_IDLE : cfir_pkg::MS_SUM;
				end
			end
			default: state_d = cfir_pkg::MS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cfir_pkg::MS_IDLE;
			r_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == cfir_pkg::MS_IDLE) begin
				r_q <= '0;
			end
			if (state_q == cfir_pkg::MS_OUT) begin
				out_valid_q <= 1'b1;
			end else if (state_q == cfir_pkg::MS_WAIT && out_ready) begin
				out_valid_q <= 1'b0;
				r_q         <= r_q + RW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			cfir_pkg::MS_SUM: begin
				sum_re_q <= sum_re_d;
				sum_im_q <= sum_im_d;
			end
			cfir_pkg::MS_MUL: begin
				plo_re_q <= sum_re_q * $signed({1'b0, gain[7:0]});
				phi_re_q <= sum_re_q * $signed({1'b0, gain[15:8]});
				plo_im_q <= sum_im_q * $signed({1'b0, gain[7:0]});
				phi_im_q <= sum_im_q * $signed({1'b0, gain[15:8]});
			end
			cfir_pkg::MS_ADD: begin
				tot_re_q <= (TW'(phi_re_q) <<< 8) + TW'(plo_re_q);
				tot_im_q <= (TW'(phi_im_q) <<< 8) + TW'(plo_im_q);
			end
			cfir_pkg::MS_OUT: begin
				rx_index  <= 2'(r_q);
				out_re    <= sat_re_hi ? 16'sh7fff : (sat_re_lo ? 16'sh8000 : 16'(q_re));
				out_im    <= sat_im_hi ? 16'sh7fff : (sat_im_lo ? 16'sh8000 : 16'(q_im));
				saturated <= sat_re_hi | sat_re_lo | sat_im_hi | sat_im_lo;
				last      <= r_last;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign busy      = state_q != cfir_pkg::MS_IDLE;
endmodule
`default_nettype wire

>>> src/mimo_complex_fir_int16_top.sv
// Top level: configuration, tap loading, tap sequencing over parallel antenna pair lanes.
// A sample word runs a tap sweep over num_taps positions, then a pipeline drain, then
// the merge, which offers one result per receive antenna, each held until out_ready.
// No new sample word or tap load is accepted until that merge is done.
// The tap sweep reads one tap position per cycle from every lane's tap memory at once.
// Reset clears control, registers to 1/1/1/16384 and history; tap memory is undefined.
`default_nettype none
module mimo_complex_fir_int16_top #(
	parameter int MAX_RX   = cfir_pkg::DEF_MAX_RX,
	parameter int MAX_TX   = cfir_pkg::DEF_MAX_TX,
	parameter int MAX_TAPS = cfir_pkg::DEF_MAX_TAPS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [cfir_pkg::CFG_IW-1:0]         cfg_index,
	input  wire logic [cfir_pkg::CFG_DW-1:0]         cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                func,
	input  wire logic [cfir_pkg::ADDR_W-1:0]         tap_address,
	input  wire logic                                frame_last,
	input  wire logic signed [cfir_pkg::SAMP_W-1:0]  value_re_0,
	input  wire logic signed [cfir_pkg::SAMP_W-1:0]  value_im_0,
	input  wire logic signed [cfir_pkg::SAMP_W-1:0]  value_re_1,
	input  wire logic signed [cfir_pkg::SAMP_W-1:0]  value_im_1,
	input  wire logic signed [cfir_pkg::SAMP_W-1:0]  value_re_2,
	input  wire logic signed [cfir_pkg::SAMP_W-1:0]  value_im_2,
	input  wire logic signed [cfir_pkg::SAMP_W-1:0]  value_re_3,
	input  wire logic signed [cfir_pkg::SAMP_W-1:0]  value_im_3,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [1:0]                               rx_index,
	output logic signed [cfir_pkg::SAMP_W-1:0]       out_re,
	output logic signed [cfir_pkg::SAMP_W-1:0]       out_im,
	output logic                                     saturated,
	output logic                                     last
);
	localparam int IW    = cfir_pkg::idx_w(MAX_TAPS);
	localparam int CW    = $clog2(MAX_TAPS + 1);
	localparam int NRW   = $clog2(MAX_RX + 1);
	localparam int NTW   = $clog2(MAX_TX + 1);
	localparam int ACC_W = cfir_pkg::acc_w(MAX_TAPS);
	localparam int NL    = MAX_RX * MAX_TX;

	cfir_pkg::top_state_t state_q, state_d;
	logic [2:0]  num_rx_q, num_tx_q;
	logic [5:0]  num_taps_q;
	logic [cfir_pkg::GAIN_W-1:0] gain_q;
	logic [NRW-1:0] nr;
	logic [NTW-1:0] nt;
	logic [CW-1:0]  nl;
	logic [CW-1:0]  d_q, cnt_q;
	logic [1:0]     drain_q;
	logic           flast_q;
	logic           in_acc, samp_acc, load_acc;
	logic           merge_start, merge_busy;
	cfir_pkg::pipe_ctl_t ctl;
	logic signed [cfir_pkg::SAMP_W-1:0] v_re [cfir_pkg::PORT_TX];
	logic signed [cfir_pkg::SAMP_W-1:0] v_im [cfir_pkg::PORT_TX];
	logic signed [cfir_pkg::SAMP_W-1:0] s_re [MAX_TX];
	logic signed [cfir_pkg::SAMP_W-1:0] s_im [MAX_TX];
	logic signed [ACC_W-1:0] acc_re [NL];
	logic signed [ACC_W-1:0] acc_im [NL];

	assign v_re[0] = value_re_0;
	assign v_im[0] = value_im_0;
	assign v_re[1] = value_re_1;
	assign v_im[1] = value_im_1;
	assign v_re[2] = value_re_2;
	assign v_im[2] = value_im_2;
	assign v_re[3] = value_re_3;
	assign v_im[3] = value_im_3;

	always_comb begin
		if (num_rx_q == '0) begin
			nr = NRW'(1);
		end else if (32'(num_rx_q) > MAX_RX) begin
			nr = NRW'(MAX_RX);
		end else begin
			nr = NRW'(num_rx_q);
		end
		if (num_tx_q == '0) begin
			nt = NTW'(1);
		end else if (32'(num_tx_q) > MAX_TX) begin
			nt = NTW'(MAX_TX);
		end else begin
			nt = NTW'(num_tx_q);
		end
		if (num_taps_q == '0) begin
			nl = CW'(1);
		end else if (32'(num_taps_q) > MAX_TAPS) begin
			nl = CW'(MAX_TAPS);
		end else begin
			nl = CW'(num_taps_q);
		end
	end

	assign in_ready = state_q == cfir_pkg::ST_IDLE;
	assign in_acc   = in_valid && in_ready;
	assign samp_acc = in_acc && func == cfir_pkg::FUNC_SAMPLE;
	assign load_acc = in_acc && func == cfir_pkg::FUNC_LOAD;
	assign ctl.vld     = state_q == cfir_pkg::ST_RUN;
	assign ctl.use_tap = d_q < cnt_q;
	assign merge_start = state_q == cfir_pkg::ST_DRAIN && drain_q == 2'd2;

	always_comb begin
		state_d = state_q;
		case (state_q)
			cfir_pkg::ST_IDLE:  if (samp_acc) state_d = cfir_pkg::ST_RUN;
			cfir_pkg::ST_RUN:   if (d_q == nl - CW'(1)) state_d = cfir_pkg::ST_DRAIN;
			cfir_pkg::ST_DRAIN: if (drain_q == 2'd2) state_d = cfir_pkg::ST_MERGE;
			cfir_pkg::ST_MERGE: if (!merge_busy) state_d = cfir_pkg::ST_IDLE;
			default: state_d = cfir_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= cfir_pkg::ST_IDLE;
			num_rx_q   <= 3'd1;
			num_tx_q   <= 3'd1;
			num_taps_q <= 6'd1;
			gain_q     <= 16'd16384;
			d_q        <= '0;
			cnt_q      <= '0;
			drain_q    <= '0;
			flast_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					cfir_pkg::REG_NUM_RX:   num_rx_q   <= cfg_data[2:0];
					cfir_pkg::REG_NUM_TX:   num_tx_q   <= cfg_data[2:0];
					cfir_pkg::REG_NUM_TAPS: num_taps_q <= cfg_data[5:0];
					cfir_pkg::REG_GAIN:     gain_q     <= cfg_data;
					default: begin
					end
				endcase
			end
			if (samp_acc) begin
				flast_q <= frame_last;
				d_q     <= '0;
				if (32'(cnt_q) != MAX_TAPS) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
			if (state_q == cfir_pkg::ST_RUN) begin
				d_q     <= d_q + CW'(1);
				drain_q <= '0;
			end
			if (state_q == cfir_pkg::ST_DRAIN) begin
				drain_q <= drain_q + 2'd1;
			end
			if (state_q == cfir_pkg::ST_MERGE && !merge_busy && flast_q) begin
				cnt_q <= '0;
			end
		end
	end

	for (genvar t = 0; t < MAX_TX; t++) begin : g_hist
		cfir_hist #(.MAX_TAPS(MAX_TAPS), .IW(IW), .CW(CW)) u_hist (
			.clk     (clk),
			.arst_n  (arst_n),
			.push    (samp_acc),
			.push_re (v_re[t]),
			.push_im (v_im[t]),
			.rd_d    (d_q),
			.samp_re (s_re[t]),
			.samp_im (s_im[t])
		);
	end

	for (genvar r = 0; r < MAX_RX; r++) begin : g_rx
		for (genvar t = 0; t < MAX_TX; t++) begin : g_tx
			localparam int L    = r * MAX_TX + t;
			localparam int BASE = L * MAX_TAPS;
			logic wr_hit;
			logic [31:0] rel;
			assign rel    = 32'(tap_address) - 32'(BASE);
			assign wr_hit = load_acc && 32'(tap_address) >= 32'(BASE) &&
				32'(tap_address) < 32'(BASE + MAX_TAPS);
			cfir_lane #(.MAX_TAPS(MAX_TAPS), .IW(IW), .ACC_W(ACC_W)) u_lane (
				.clk     (clk),
				.arst_n  (arst_n),
				.wr_en   (wr_hit),
				.wr_addr (rel[IW-1:0]),
				.wr_re   (value_re_0),
				.wr_im   (value_im_0),
				.rd_addr (d_q[IW-1:0]),
				.ctl     (ctl),
				.act     (NTW'(t) < nt),
				.clr     (samp_acc),
				.samp_re (s_re[t]),
				.samp_im (s_im[t]),
				.acc_re  (acc_re[L]),
				.acc_im  (acc_im[L])
			);
		end
	end

	cfir_merge #(
		.MAX_RX(MAX_RX), .MAX_TX(MAX_TX), .MAX_TAPS(MAX_TAPS), .ACC_W(ACC_W), .NRW(NRW)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (merge_start),
		.nr        (nr),
		.gain      (gain_q),
		.acc_re    (acc_re),
		.acc_im    (acc_im),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.rx_index  (rx_index),
		.out_re    (out_re),
		.out_im    (out_im),
		.saturated (saturated),
		.last      (last),
		.busy      (merge_busy)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == cfir_pkg::ST_MERGE)
		else $error("result word outside merge phase");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cfir_pkg::ST_RUN |-> d_q < nl)
		else $error("tap index beyond tap count");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cfir_pkg::ST_IDLE |-> !merge_busy)
		else $error("merge busy while idle");
endmodule
`default_nettype wire
